/* rtl/tdit_pkg.sv */
// Shared types and constants for the tag to dense index table.
// No dependencies; used by every module of the block.
package tdit_pkg;

   localparam int unsigned CAPACITY = 1024;
   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = IDX_W + 1;

   // operation codes (req_tuser)
   localparam logic [2:0] MODE_ADD     = 3'd0;
   localparam logic [2:0] MODE_REMOVE  = 3'd1;
   localparam logic [2:0] MODE_TAG_AT  = 3'd2;
   localparam logic [2:0] MODE_POS_OF  = 3'd3;
   localparam logic [2:0] MODE_SET_TAG = 3'd4;
   localparam logic [2:0] MODE_EXISTS  = 3'd5;

   // status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NO_TAGS   = 2'd1;
   localparam logic [1:0] STAT_ABSENT    = 2'd2;
   localparam logic [1:0] STAT_POS_RANGE = 2'd3;

   // special values
   localparam logic signed [CNT_W-1:0] VAL_REMOVED = -11'sd1;
   localparam logic signed [CNT_W-1:0] VAL_RANGE   = -11'sd2;

   typedef struct packed {
      logic clear;      // clear one tag-map entry
      logic load;       // capture request beat
      logic eval;       // evaluate operation
      logic rem_move;   // remove: move last entry into freed slot
      logic rem_free;   // remove: mark tag and last slot free
      logic publish;    // load output register
   } dp_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic rem_go;
      logic out_free;
   } dp_stat_type;

endpackage

/* rtl/tdit_dp.sv */
// Datapath: both map memories, counters, operands and output register.
// Depends on tdit_pkg; driven by tdit_ctrl commands.
module tdit_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  tdit_pkg::dp_cmd_type cmd,
   output tdit_pkg::dp_stat_type stat,
   input  logic [31:0]          req_tdata,
   input  logic [2:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [39:0]          rsp_tdata
);
   localparam int unsigned IW = tdit_pkg::IDX_W;
   localparam int unsigned CW = tdit_pkg::CNT_W;
   localparam logic [CW-1:0] CAP = CW'(tdit_pkg::CAPACITY);

   logic signed [CW-1:0] pot_mem [tdit_pkg::CAPACITY];
   logic signed [CW-1:0] top_mem [tdit_pkg::CAPACITY];
   logic signed [CW-1:0] pot_rd_ff, top_rd_ff;
   logic                 pot_we, top_we;
   logic [IW-1:0]        pot_wa, top_wa, pot_ra, top_ra;
   logic signed [CW-1:0] pot_wd, top_wd;

   logic [2:0]    mode_ff;
   logic [IW-1:0] tag_ff, pos_ff, ntag_ff;
   logic signed [CW-1:0] slot_ff, slot_in;
   logic [CW-1:0] lc_ff, lc_in, nft_ff, nft_in, tlen_ff, tlen_in, plen_ff, plen_in;
   logic [IW-1:0] clr_ff;
   logic signed [CW-1:0] val_ff, val_in;
   logic          ex_ff, ex_in;
   logic [1:0]    st_ff, st_in;
   logic          rem_go;
   logic          out_vld_ff;
   logic [39:0]   out_ff;

   logic tag_oob;
   logic signed [CW-1:0] last_tag;

   always_ff @(posedge clock) begin
      if (pot_we) pot_mem[pot_wa] <= pot_wd;
      pot_rd_ff <= pot_mem[pot_ra];
   end

   always_ff @(posedge clock) begin
      if (top_we) top_mem[top_wa] <= top_wd;
      top_rd_ff <= top_mem[top_ra];
   end

   assign tag_oob  = {1'b0, tag_ff} >= tlen_ff;
   assign last_tag = top_rd_ff;

   always_comb begin
      pot_we  = 1'b0;
      pot_wa  = tag_ff;
      pot_wd  = '0;
      top_we  = 1'b0;
      top_wa  = pos_ff;
      top_wd  = '0;
      pot_ra  = tag_ff;
      top_ra  = pos_ff;
      lc_in   = lc_ff;
      nft_in  = nft_ff;
      tlen_in = tlen_ff;
      plen_in = plen_ff;
      slot_in = slot_ff;
      val_in  = val_ff;
      ex_in   = ex_ff;
      st_in   = st_ff;
      rem_go  = 1'b0;
      if (cmd.clear) begin
         pot_we = 1'b1;
         pot_wa = clr_ff;
         pot_wd = '0;
      end
      if (cmd.eval) begin
         val_in = '0;
         ex_in  = 1'b0;
         st_in  = tdit_pkg::STAT_OK;
         case (mode_ff)
            tdit_pkg::MODE_ADD: begin
               if (nft_ff >= CAP || lc_ff >= CAP) begin
                  st_in  = tdit_pkg::STAT_NO_TAGS;
                  val_in = tdit_pkg::VAL_RANGE;
               end else begin
                  pot_we = 1'b1;
                  pot_wa = nft_ff[IW-1:0];
                  pot_wd = lc_ff;
                  top_we = 1'b1;
                  top_wa = lc_ff[IW-1:0];
                  top_wd = nft_ff;
                  if (nft_ff + 1'b1 > tlen_ff) tlen_in = nft_ff + 1'b1;
                  if (lc_ff + 1'b1 > plen_ff) plen_in = lc_ff + 1'b1;
                  lc_in  = lc_ff + 1'b1;
                  nft_in = nft_ff + 1'b1;
                  val_in = nft_ff;
               end
            end
            tdit_pkg::MODE_REMOVE: begin
               if (tag_oob) begin
                  val_in = tdit_pkg::VAL_RANGE;
               end else begin
                  val_in = tdit_pkg::VAL_REMOVED;
                  if (pot_rd_ff[CW-1] || lc_ff == '0) begin
                     st_in = tdit_pkg::STAT_ABSENT;
                  end else begin
                     lc_in   = lc_ff - 1'b1;
                     top_ra  = lc_in[IW-1:0];
                     slot_in = pot_rd_ff;
                     rem_go  = 1'b1;
                  end
               end
            end
            tdit_pkg::MODE_TAG_AT: begin
               val_in = ({1'b0, pos_ff} >= lc_ff) ? tdit_pkg::VAL_RANGE : top_rd_ff;
            end
            tdit_pkg::MODE_POS_OF, tdit_pkg::MODE_EXISTS: begin
               if (tag_oob) begin
                  val_in = tdit_pkg::VAL_RANGE;
               end else begin
                  val_in = pot_rd_ff;
                  ex_in  = (mode_ff == tdit_pkg::MODE_EXISTS) && !pot_rd_ff[CW-1];
               end
            end
            tdit_pkg::MODE_SET_TAG: begin
               if ({1'b0, pos_ff} >= plen_ff) begin
                  st_in  = tdit_pkg::STAT_POS_RANGE;
                  val_in = tdit_pkg::VAL_RANGE;
               end else begin
                  top_we = 1'b1;
                  top_wa = pos_ff;
                  top_wd = {1'b0, ntag_ff};
                  pot_we = 1'b1;
                  pot_wa = ntag_ff;
                  pot_wd = {1'b0, pos_ff};
                  if ({1'b0, ntag_ff} >= tlen_ff) tlen_in = {1'b0, ntag_ff} + 1'b1;
                  if (nft_ff < {1'b0, ntag_ff}) begin
                     nft_in = {1'b0, ntag_ff} + 1'b1;
                  end else if (nft_ff != '0 && (nft_ff - 1'b1) == top_rd_ff) begin
                     nft_in = nft_ff - 1'b1;
                  end
                  val_in = top_rd_ff;
               end
            end
            default: begin
               val_in = '0;
            end
         endcase
      end
      if (cmd.rem_move) begin
         // last entry takes the freed slot
         if (!last_tag[CW-1] && last_tag < tlen_ff) begin
            pot_we = 1'b1;
            pot_wa = last_tag[IW-1:0];
            pot_wd = slot_ff;
         end
         top_we = 1'b1;
         top_wa = slot_ff[IW-1:0];
         top_wd = last_tag;
      end
      if (cmd.rem_free) begin
         pot_we = 1'b1;
         pot_wa = tag_ff;
         pot_wd = tdit_pkg::VAL_REMOVED;
         top_we = 1'b1;
         top_wa = lc_ff[IW-1:0];
         top_wd = tdit_pkg::VAL_REMOVED;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_tuser;
         tag_ff  <= req_tdata[9:0];
         pos_ff  <= req_tdata[19:10];
         ntag_ff <= req_tdata[29:20];
      end
      slot_ff <= slot_in;
      val_ff  <= val_in;
      ex_ff   <= ex_in;
      st_ff   <= st_in;
      if (cmd.publish) begin
         out_ff <= {4'd0, st_ff, nft_ff - 1'b1, lc_ff, ex_ff, val_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_ff      <= '0;
         nft_ff     <= '0;
         tlen_ff    <= '0;
         plen_ff    <= '0;
         clr_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         lc_ff   <= lc_in;
         nft_ff  <= nft_in;
         tlen_ff <= tlen_in;
         plen_ff <= plen_in;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.publish) out_vld_ff <= 1'b1;
         else if (rsp_tready) out_vld_ff <= 1'b0;
      end
   end

   assign stat.clear_done = (clr_ff == {IW{1'b1}});
   assign stat.rem_go     = rem_go;
   assign stat.out_free   = !out_vld_ff || rsp_tready;
   assign rsp_tvalid      = out_vld_ff;
   assign rsp_tdata       = out_ff;
endmodule

/* rtl/tdit_ctrl.sv */
// Controller: sequences clear pass, lookup, update and response.
// Depends on tdit_pkg; commands tdit_dp.
module tdit_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tdit_pkg::dp_stat_type stat,
   output tdit_pkg::dp_cmd_type  cmd
);
   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_EVAL, S_REM_MOVE, S_REM_FREE, S_RESP
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (stat.clear_done) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= S_READ;
                  ready_ff <= 1'b0;
               end
            end
            S_READ: state_ff <= S_EVAL;
            S_EVAL: state_ff <= stat.rem_go ? S_REM_MOVE : S_RESP;
            S_REM_MOVE: state_ff <= S_REM_FREE;
            S_REM_FREE: state_ff <= S_RESP;
            S_RESP: begin
               if (stat.out_free) begin
                  state_ff <= S_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_CLEAR;
               ready_ff <= 1'b0;
            end
         endcase
      end
   end

   assign req_tready   = ready_ff;
   assign cmd.clear    = (state_ff == S_CLEAR);
   assign cmd.load     = ready_ff && req_tvalid;
   assign cmd.eval     = (state_ff == S_EVAL);
   assign cmd.rem_move = (state_ff == S_REM_MOVE);
   assign cmd.rem_free = (state_ff == S_REM_FREE);
   assign cmd.publish  = (state_ff == S_RESP) && stat.out_free;
endmodule

/* rtl/tag_to_dense_index_table_core.sv */
// Tag to dense index table: sparse set with swap-on-remove.
// A request passes S_READ and S_EVAL, plus S_REM_MOVE and S_REM_FREE for a remove that
// frees a tag, then S_RESP loads the result beat; one op in flight, no new beat until then.
// Reset: synchronous, clears counters, then a clearing pass over the tag map with
// req_tready low. Depends on tdit_pkg, tdit_ctrl, tdit_dp.
module tag_to_dense_index_table_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // tag[9:0], position[19:10], new_tag[29:20]
   input  logic [2:0]  req_tuser,  // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // value[10:0], exists[11], entry_count[22:12],
                                   // highest_tag[33:23], status[35:34]
);
   tdit_pkg::dp_cmd_type  cmd;
   tdit_pkg::dp_stat_type stat;

   // sequencer: one op at a time, memory ports set the step count
   tdit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // both maps, counters and the output register
   tdit_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule

/* rtl/tdit_checker.sv */
// Port-level checks for the tag to dense index table.
// Depends on tdit_pkg; bound to tag_to_dense_index_table_core.
module tdit_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat taken while busy");

   a_no_tags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[35:34] == tdit_pkg::STAT_NO_TAGS |->
      rsp_tdata[10:0] == tdit_pkg::VAL_RANGE)
      else $error("out of tags without range value");

   a_exists: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |->
      rsp_tdata[35:34] == tdit_pkg::STAT_OK && !rsp_tdata[10])
      else $error("exists flag with bad value");
endmodule

bind tag_to_dense_index_table_core tdit_checker u_tdit_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
